@@ hw/rtl/spa_pkg.sv @@
// spa_pkg: shared types and codes of the slot pool allocator
// no dependencies
package spa_pkg;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_FIND  = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
	localparam logic [1:0] STATUS_INACTIVE = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_REL_RD,
		ST_REL_EVAL,
		ST_REL_WR,
		ST_ALC_RD,
		ST_ALC_EVAL,
		ST_FND_RD,
		ST_FND_CMP,
		ST_FIN
	} state_t;

endpackage

@@ hw/rtl/spa_req_if.sv @@
// spa_req_if: request channel of the slot pool allocator
// no dependencies
interface spa_req_if #(
	parameter int SW = 11
);
	logic          valid;
	logic          ready;
	logic [1:0]    func;
	logic [SW-1:0] slot_index;
	logic [31:0]   search_id;

	modport source (output valid, func, slot_index, search_id, input ready);
	modport sink (input valid, func, slot_index, search_id, output ready);
endinterface

@@ hw/rtl/spa_rsp_if.sv @@
// spa_rsp_if: result channel of the slot pool allocator
// no dependencies
interface spa_rsp_if #(
	parameter int SW = 11
);
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [SW-1:0] result_slot;
	logic [31:0]   result_id;
	logic          evicted;
	logic [SW-1:0] evicted_slot;

	modport source (output valid, status, result_slot, result_id, evicted, evicted_slot,
		input ready);
	modport sink (input valid, status, result_slot, result_id, evicted, evicted_slot,
		output ready);
endinterface

@@ hw/rtl/spa_ram.sv @@
// spa_ram: generic one-write one-read ram with registered read
// no dependencies
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/slot_pool_allocator_oldest_evict_core.sv @@
// Slot pool allocator with oldest-slot eviction, top level
// depends on spa_pkg, spa_req_if, spa_rsp_if, spa_ram
//
// Usage: requests come in on req (func, slot_index, search_id), one result
// per request leaves on rsp. Both are valid/ready channels; a transfer
// happens when valid and ready are both high at a clock edge.
// A small sequencer drives three rams (link word with active bit, newer
// link, serial id) through one shared read address, one access a cycle.
// An alloc on a full pool first frees the oldest slot; a find walks the
// active slots from oldest to newest and stops at the first match.
// One request is worked at a time; req.ready is high only while the
// sequencer is idle. The result register lets the next request start while
// a result still waits; if rsp is stalled, the sequencer holds its finished
// result until the result register drains.
// After reset the link ram is initialized, one slot a cycle, and req.ready
// stays low until that is done.
module slot_pool_allocator_oldest_evict_core #(
	parameter int POOL_SLOTS = 2048
) (
	input  logic clk,
	input  logic arst_n,
	spa_req_if.sink   req,
	spa_rsp_if.source rsp
);
	import spa_pkg::*;

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int CW = $clog2(POOL_SLOTS + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_SLOTS);

	state_t state_q, state_d;

	logic [SW-1:0] init_q, free_head_q, newest_q, oldest_q;
	logic [CW-1:0] free_count_q, k_q;
	logic [31:0]   serial_q;
	logic          out_valid_q;

	logic [1:0]    func_q;
	logic [31:0]   sid_q;
	logic [SW-1:0] rel_q, walk_q;
	logic [1:0]    res_status_q;
	logic [SW-1:0] res_slot_q, res_evslot_q;
	logic [31:0]   res_id_q;
	logic          res_ev_q;

	logic [1:0]    out_status_q;
	logic [SW-1:0] out_slot_q, out_evslot_q;
	logic [31:0]   out_id_q;
	logic          out_ev_q;

	// ram ports
	logic [SW-1:0] rd_addr;
	logic [SW:0]   link_rd, link_wdata;
	logic [SW-1:0] link_waddr, prev_rd, prev_waddr, prev_wdata;
	logic          link_we, prev_we, ser_we;
	logic [31:0]   ser_rd;

	logic          accept, fin_load, in_range, is_old, is_new, middle, rel_act;
	logic          alloc_evict;
	logic [SW-1:0] older, newer;
	logic [CW-1:0] active_n;

	assign accept      = req.valid && req.ready;
	assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	assign in_range    = {1'b0, req.slot_index} < FULL_COUNT;
	assign alloc_evict = (req.func == FUNC_ALLOC) && (free_count_q == '0);
	assign rel_act     = link_rd[SW];
	assign older       = link_rd[SW-1:0];
	assign newer       = prev_rd;
	assign is_old      = rel_q == oldest_q;
	assign is_new      = rel_q == newest_q;
	assign middle      = !is_old && !is_new;
	assign active_n    = FULL_COUNT - free_count_q;

	spa_ram #(.WIDTH(SW + 1), .DEPTH(POOL_SLOTS)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(rd_addr), .rdata(link_rd)
	);
	spa_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(rd_addr), .rdata(prev_rd)
	);
	spa_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_serial (
		.clk(clk), .we(ser_we), .waddr(free_head_q), .wdata(serial_q),
		.raddr(rd_addr), .rdata(ser_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_q == SW'(POOL_SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.func)
						FUNC_ALLOC: state_d = (free_count_q == '0) ? ST_REL_RD : ST_ALC_RD;
						FUNC_FREE:  state_d = in_range ? ST_REL_RD : ST_FIN;
						FUNC_FIND:  state_d = (free_count_q == FULL_COUNT) ? ST_FIN : ST_FND_RD;
						default:    state_d = ST_FIN;
					endcase
				end
			end
			ST_REL_RD:   state_d = ST_REL_EVAL;
			ST_REL_EVAL: state_d = (func_q == FUNC_FREE && !rel_act) ? ST_FIN : ST_REL_WR;
			ST_REL_WR:   state_d = (func_q == FUNC_ALLOC) ? ST_ALC_RD : ST_FIN;
			ST_ALC_RD:   state_d = ST_ALC_EVAL;
			ST_ALC_EVAL: state_d = ST_FIN;
			ST_FND_RD:   state_d = ST_FND_CMP;
			ST_FND_CMP: begin
				if (ser_rd == sid_q || k_q + CW'(1) == active_n) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		rd_addr    = rel_q;
		link_we    = 1'b0;
		link_waddr = rel_q;
		link_wdata = {1'b0, free_head_q};
		prev_we    = 1'b0;
		prev_waddr = older;
		prev_wdata = newer;
		ser_we     = 1'b0;
		case (state_q)
			ST_INIT: begin
				link_we    = 1'b1;
				link_waddr = init_q;
				link_wdata = {1'b0, (init_q == SW'(POOL_SLOTS - 1)) ? SW'(0) : init_q + SW'(1)};
			end
			ST_ALC_RD: rd_addr = free_head_q;
			ST_FND_RD: rd_addr = oldest_q;
			ST_FND_CMP: rd_addr = prev_rd;
			ST_REL_EVAL: begin
				if (middle && !(func_q == FUNC_FREE && !rel_act)) begin
					link_we    = 1'b1;
					link_waddr = newer;
					link_wdata = {1'b1, older};
					prev_we    = 1'b1;
				end
			end
			ST_REL_WR: link_we = 1'b1;
			ST_ALC_EVAL: begin
				link_we    = 1'b1;
				link_waddr = free_head_q;
				// first active slot keeps its old link
				link_wdata = (free_count_q == FULL_COUNT) ? {1'b1, older} : {1'b1, newest_q};
				prev_we    = free_count_q != FULL_COUNT;
				prev_waddr = newest_q;
				prev_wdata = free_head_q;
				ser_we     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			init_q       <= '0;
			free_head_q  <= '0;
			free_count_q <= FULL_COUNT;
			newest_q     <= '0;
			oldest_q     <= '0;
			serial_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) init_q <= init_q + SW'(1);
			if (state_q == ST_REL_EVAL && !(func_q == FUNC_FREE && !rel_act)) begin
				if (is_old && !is_new) oldest_q <= newer;
				else if (is_new && !is_old) newest_q <= older;
			end
			if (state_q == ST_REL_WR) begin
				free_head_q  <= rel_q;
				free_count_q <= free_count_q + CW'(1);
			end
			if (state_q == ST_ALC_EVAL) begin
				free_head_q  <= older;
				free_count_q <= free_count_q - CW'(1);
				if (free_count_q == FULL_COUNT) oldest_q <= free_head_q;
				newest_q <= free_head_q;
				serial_q <= serial_q + 32'd1;
			end
			if (fin_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= req.func;
			sid_q        <= req.search_id;
			rel_q        <= alloc_evict ? oldest_q : req.slot_index;
			k_q          <= '0;
			res_slot_q   <= '0;
			res_id_q     <= '0;
			res_ev_q     <= alloc_evict;
			res_evslot_q <= alloc_evict ? oldest_q : '0;
			case (req.func)
				FUNC_FREE: res_status_q <= in_range ? STATUS_OK : STATUS_INACTIVE;
				FUNC_FIND: res_status_q <= STATUS_NOTFOUND;
				default:   res_status_q <= STATUS_OK;
			endcase
		end
		if (state_q == ST_FND_RD) walk_q <= oldest_q;
		if (state_q == ST_REL_EVAL && func_q == FUNC_FREE && !rel_act) begin
			res_status_q <= STATUS_INACTIVE;
		end
		if (state_q == ST_ALC_EVAL) begin
			res_slot_q <= free_head_q;
			res_id_q   <= serial_q;
		end
		if (state_q == ST_FND_CMP) begin
			if (ser_rd == sid_q) begin
				res_status_q <= STATUS_OK;
				res_slot_q   <= walk_q;
				res_id_q     <= sid_q;
			end else begin
				k_q    <= k_q + CW'(1);
				walk_q <= prev_rd;
			end
		end
		if (fin_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_id_q     <= res_id_q;
			out_ev_q     <= res_ev_q;
			out_evslot_q <= res_evslot_q;
		end
	end

	assign req.ready        = state_q == ST_IDLE;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_slot  = out_slot_q;
	assign rsp.result_id    = out_id_q;
	assign rsp.evicted      = out_ev_q;
	assign rsp.evicted_slot = out_evslot_q;
endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for slot_pool_allocator_oldest_evict_core
// depends on spa_pkg, spa_req_if, spa_rsp_if and the core rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spa_pkg::*;

	localparam int NSLOT = 2048;
	localparam int WATCH_LIMIT = 20000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [10:0] slot_index;
		logic [31:0] search_id;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] result_slot;
		logic [31:0] result_id;
		logic        evicted;
		logic [10:0] evicted_slot;
	} result_t;

	logic clk;
	logic arst_n;

	spa_req_if #(.SW(11)) req ();
	spa_rsp_if #(.SW(11)) rsp ();

	slot_pool_allocator_oldest_evict_core #(.POOL_SLOTS(NSLOT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	request_t pending_q[$];
	result_t  expected_q[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit hold_off = 0;
	bit no_idle = 0;

	// pool model
	logic [10:0] older_of[NSLOT];
	logic [10:0] newer_of[NSLOT];
	bit          in_use[NSLOT];
	logic [31:0] serial_of[NSLOT];
	logic [10:0] free_top;
	int          free_slots;
	logic [10:0] newest;
	logic [10:0] oldest;
	logic [31:0] next_serial;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void pool_reset();
		for (int i = 0; i < NSLOT; i++) begin
			older_of[i] = 11'((i + 1) % NSLOT);
			newer_of[i] = '0;
			in_use[i] = 0;
			serial_of[i] = '0;
		end
		free_top = '0;
		free_slots = NSLOT;
		newest = '0;
		oldest = '0;
		next_serial = '0;
	endfunction

	function automatic void unlink_slot(logic [10:0] s);
		logic [10:0] o;
		logic [10:0] n;
		o = older_of[s];
		n = newer_of[s];
		if (s == oldest && s == newest) begin
		end else if (s == oldest) begin
			oldest = n;
		end else if (s == newest) begin
			newest = o;
		end else begin
			older_of[n] = o;
			newer_of[o] = n;
		end
		in_use[s] = 0;
		older_of[s] = free_top;
		free_top = s;
		free_slots++;
	endfunction

	function automatic result_t pool_apply(request_t r);
		result_t res;
		logic [10:0] s;
		int live;
		res = '0;
		case (r.func)
			FUNC_ALLOC: begin
				if (free_slots == 0) begin
					res.evicted = 1'b1;
					res.evicted_slot = oldest;
					unlink_slot(oldest);
				end
				live = NSLOT - free_slots;
				s = free_top;
				free_top = older_of[s];
				free_slots--;
				if (live == 0) begin
					oldest = s;
				end else begin
					older_of[s] = newest;
					newer_of[newest] = s;
				end
				newest = s;
				in_use[s] = 1;
				serial_of[s] = next_serial;
				next_serial++;
				res.result_slot = s;
				res.result_id = serial_of[s];
			end
			FUNC_FREE: begin
				if (in_use[r.slot_index])
					unlink_slot(r.slot_index);
				else
					res.status = STATUS_INACTIVE;
			end
			FUNC_FIND: begin
				live = NSLOT - free_slots;
				s = oldest;
				res.status = STATUS_NOTFOUND;
				for (int k = 0; k < live; k++) begin
					if (serial_of[s] == r.search_id) begin
						res.status = STATUS_OK;
						res.result_slot = s;
						res.result_id = r.search_id;
						break;
					end
					s = newer_of[s];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: request side and rsp.ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 0;
			req.func <= FUNC_ALLOC;
			req.slot_index <= '0;
			req.search_id <= '0;
			rsp.ready <= 0;
		end else begin
			rsp.ready <= no_idle || ($urandom_range(0, 99) >= 33);
			if (!req.valid || req.ready) begin
				if (hold_off || pending_q.size() == 0
						|| (!no_idle && $urandom_range(0, 99) < 33)) begin
					req.valid <= 0;
				end else begin
					request_t r;
					r = pending_q.pop_front();
					req.valid <= 1;
					req.func <= r.func;
					req.slot_index <= r.slot_index;
					req.search_id <= r.search_id;
				end
			end
		end
	end

	// monitor: predict on accepted requests, check results in order
	always @(posedge clk) begin
		if (arst_n) begin
			bit moved;
			moved = 0;
			if (req.valid && req.ready) begin
				expected_q.push_back(pool_apply({req.func, req.slot_index, req.search_id}));
				moved = 1;
			end
			if (rsp.valid && rsp.ready) begin
				moved = 1;
				if (expected_q.size() == 0) begin
					report("unexpected result", 32'(rsp.status), 32'd0);
				end else begin
					result_t w;
					w = expected_q.pop_front();
					if (rsp.status !== w.status)
						report("status", 32'(rsp.status), 32'(w.status));
					if (rsp.result_slot !== w.result_slot)
						report("result_slot", 32'(rsp.result_slot), 32'(w.result_slot));
					if (rsp.result_id !== w.result_id)
						report("result_id", rsp.result_id, w.result_id);
					if (rsp.evicted !== w.evicted)
						report("evicted", 32'(rsp.evicted), 32'(w.evicted));
					if (rsp.evicted_slot !== w.evicted_slot)
						report("evicted_slot", 32'(rsp.evicted_slot), 32'(w.evicted_slot));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("watchdog expired at %0t", $realtime);
				$display("[slot_pool_allocator_oldest_evict_core] ERROR");
				$finish;
			end
		end
	end

	task automatic push(logic [1:0] f, logic [10:0] idx, logic [31:0] sid);
		while (pending_q.size() > 4) @(posedge clk);
		pending_q.push_back({f, idx, sid});
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || req.valid || expected_q.size() != 0)
			@(posedge clk);
	endtask

	// walk a few steps into the active list, from oldest toward newest or back
	function automatic logic [10:0] pick_live(int depth, bit from_old);
		logic [10:0] s;
		int live;
		live = NSLOT - free_slots;
		s = from_old ? oldest : newest;
		for (int k = 0; k < depth && k + 1 < live; k++)
			s = from_old ? newer_of[s] : older_of[s];
		return s;
	endfunction

	task automatic random_request(int p_alloc, int p_free, int p_find, int find_depth,
			ref int misses);
		int r;
		r = $urandom_range(0, 99);
		if (r < p_alloc) begin
			push(FUNC_ALLOC, 11'($urandom), $urandom);
		end else if (r < p_alloc + p_free) begin
			if ($urandom_range(0, 3) == 0)
				push(FUNC_FREE, 11'($urandom_range(0, NSLOT - 1)), $urandom);
			else
				push(FUNC_FREE, pick_live($urandom_range(0, 30), $urandom_range(0, 1) == 1),
					$urandom);
		end else if (r < p_alloc + p_free + p_find) begin
			if (misses > 0 && $urandom_range(0, 9) == 0) begin
				misses--;
				push(FUNC_FIND, 11'($urandom), $urandom);
			end else begin
				push(FUNC_FIND, 11'($urandom),
					serial_of[pick_live($urandom_range(0, find_depth), 1'b1)]);
			end
		end else begin
			push(FUNC_UNUSED, 11'($urandom), $urandom);
		end
	endtask

	initial begin
		int misses;
		pool_reset();
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed
		push(FUNC_ALLOC, 11'h7FF, 32'hFFFFFFFF);
		push(FUNC_ALLOC, 0, 0);
		push(FUNC_ALLOC, 0, 0);
		push(FUNC_FIND, 0, 0);
		push(FUNC_FIND, 0, 2);
		push(FUNC_FIND, 11'h7FF, 32'hFFFFFFFF);
		push(FUNC_FREE, 1, 0);
		push(FUNC_FREE, 1, 0);
		push(FUNC_FREE, 11'h7FF, 0);
		push(FUNC_UNUSED, 11'h7FF, 32'hFFFFFFFF);
		push(FUNC_FREE, 2, 0);
		push(FUNC_ALLOC, 0, 0);
		push(FUNC_FREE, 0, 0);
		push(FUNC_FIND, 0, 3);
		push(FUNC_FREE, 2, 0);
		push(FUNC_FIND, 0, 0);
		push(FUNC_FREE, 0, 0);
		push(FUNC_ALLOC, 0, 0);
		push(FUNC_FIND, 0, 4);

		// hold the sender until everything is back
		while (pending_q.size() != 0) @(posedge clk);
		hold_off = 1;
		drain();
		hold_off = 0;

		// mixed traffic on a lightly used pool
		misses = 20;
		for (int i = 0; i < 500; i++) begin
			no_idle = (i >= 200 && i < 350);
			random_request(45, 35, 17, 60, misses);
		end
		no_idle = 0;
		drain();

		// grow the active list with mostly allocs
		for (int i = 0; i < 600; i++) begin
			if ($urandom_range(0, 99) < 3)
				push(FUNC_FIND, 11'($urandom),
					serial_of[pick_live($urandom_range(0, 3), 1'b1)]);
			else
				push(FUNC_ALLOC, 11'($urandom), $urandom);
		end

		// churn on a busier pool
		misses = 8;
		for (int i = 0; i < 130; i++)
			random_request(50, 35, 12, 4, misses);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[slot_pool_allocator_oldest_evict_core] OK");
		else
			$display("[slot_pool_allocator_oldest_evict_core] ERROR");
		$finish;
	end
endmodule
